// ===== hdl/bsfs_pkg.sv =====
`default_nettype none
package bsfs_pkg;
  localparam int NUM_FORMATS = 16;

  localparam logic [1:0] KIND_OPCODE = 2'd0;
  localparam logic [1:0] KIND_ARG    = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;
  localparam logic       IN_BIT      = 1'b0;
  localparam logic       IN_WRITE    = 1'b1;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [3:0]  format_index;
    logic [31:0] field_value;
    logic [5:0]  field_width;
    logic        last;
  } result_t;
endpackage
`default_nettype wire

// ===== hdl/bsfs_out_reg.sv =====
`default_nettype none
module bsfs_out_reg
  import bsfs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t load_data,
  output logic         full,
  input  wire logic    take,
  output result_t      data
);
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/bit_serial_format_splitter_core.sv =====
// bit_serial_format_splitter_core
// input channel (in_valid / in_stall): kind 1 writes one format table entry,
// kind 0 appends one stream bit to the instruction buffer.
// output channel (out_valid / out_stall): opcode field, then argument fields,
// last set on the final one; an overflow error item when the buffer fills.
// cfg_we / cfg_wdata set formats_in_use; the user must do so only while the
// block is idle, which the block itself does not enforce. a stream bit is
// checked against one table entry at a time (read, then compare) by the
// shared match comparator, up to min(formats_in_use, NUM_FORMATS) entries.
// on a match the shared bit walker steps one buffer position per cycle while
// the output register is not full: an opcode pass, and when the format has
// argument fields a second pass that hands each field item to the output
// register as it closes.
// the core holds in_stall high while it works and while the output register
// is full; a stalled receiver simply holds the sequencer.
// reset clears the buffer, the count, formats_in_use and the output register's
// full flag; the table contents are undefined until written.
`default_nettype none
module bit_serial_format_splitter_core
  import bsfs_pkg::*;
#(
  parameter int MAX_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        kind,
  input  wire logic        stream_bit,
  input  wire logic [3:0]  entry_index,
  input  wire logic [5:0]  entry_length,
  input  wire logic [31:0] entry_care_mask,
  input  wire logic [31:0] entry_value_mask,
  input  wire logic [31:0] entry_run_start_mask,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       item_kind,
  output logic [3:0]       format_index,
  output logic [31:0]      field_value,
  output logic [5:0]       field_width,
  output logic             last
);
  localparam int FW = (NUM_FORMATS > 1) ? $clog2(NUM_FORMATS) : 1;
  localparam int CW = $clog2(MAX_BITS + 1);
  localparam int BW = (MAX_BITS > 32) ? MAX_BITS : 32;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_ERR   = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0]    state;
  logic [4:0]    formats_in_use;
  logic [BW-1:0] bit_buffer;
  logic [CW-1:0] bit_count;
  logic [FW:0]   search;
  logic [FW:0]   limit;

  logic [5:0]  mem_length [NUM_FORMATS];
  logic [31:0] mem_care   [NUM_FORMATS];
  logic [31:0] mem_value  [NUM_FORMATS];
  logic [31:0] mem_run    [NUM_FORMATS];
  logic [5:0]  rd_length;
  logic [31:0] rd_care, rd_value, rd_run;

  // walker state
  logic [5:0]  pos;
  logic [31:0] opv, argv;
  logic [5:0]  opw, argw;
  logic        open, prev_fixed;
  logic [3:0]  win;

  logic    ld, ob_full, take;
  result_t ld_data, ob_data;

  assign take     = ob_full && !out_stall;
  assign in_stall = (state != S_IDLE) || ob_full;
  wire accept     = in_valid && !in_stall;

  always_comb begin
    if (formats_in_use > 5'(NUM_FORMATS))
      limit = (FW+1)'(NUM_FORMATS);
    else
      limit = (FW+1)'(formats_in_use);
  end

  // table memory
  always_ff @(posedge clk) begin
    if (accept && kind == IN_WRITE && {28'd0, entry_index} < NUM_FORMATS) begin
      mem_length[entry_index[FW-1:0]] <= entry_length;
      mem_care[entry_index[FW-1:0]]   <= entry_care_mask;
      mem_value[entry_index[FW-1:0]]  <= entry_value_mask;
      mem_run[entry_index[FW-1:0]]    <= entry_run_start_mask;
    end
    rd_length <= mem_length[search[FW-1:0]];
    rd_care   <= mem_care[search[FW-1:0]];
    rd_value  <= mem_value[search[FW-1:0]];
    rd_run    <= mem_run[search[FW-1:0]];
  end

  // shared match comparator
  logic [31:0] lenmask;
  logic        hit;
  always_comb begin
    lenmask = (rd_length >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << rd_length) - 32'd1);
    hit = rd_length != 6'd0 && rd_length <= 6'd32
          && 7'(rd_length) == 7'(bit_count)
          && (((bit_buffer[31:0] ^ rd_value) & rd_care & lenmask) == 32'd0);
  end

  // walker step
  logic cur_b, cur_care, cur_run, at_end;
  assign cur_b    = bit_buffer[pos[4:0]];
  assign cur_care = rd_care[pos[4:0]];
  assign cur_run  = rd_run[pos[4:0]];
  assign at_end   = pos == rd_length;

  always_comb begin
    ld = 1'b0;
    ld_data = '0;
    ld_data.format_index = win;
    if (state == S_WALK && !ob_full && !at_end && !cur_care && open
        && (prev_fixed || cur_run)) begin
      ld = 1'b1;
      ld_data.item_kind = KIND_ARG;
      ld_data.field_value = argv;
      ld_data.field_width = argw;
    end else if (state == S_FLUSH && !ob_full) begin
      ld = 1'b1;
      ld_data.item_kind = KIND_ARG;
      ld_data.field_value = argv;
      ld_data.field_width = argw;
      ld_data.last = 1'b1;
    end else if (state == S_WALK && !ob_full && at_end) begin
      ld = 1'b1;
      ld_data.item_kind = KIND_OPCODE;
      ld_data.field_value = opv;
      ld_data.field_width = opw;
      ld_data.last = !open;
    end else if (state == S_ERR && !ob_full) begin
      ld = 1'b1;
      ld_data.item_kind = KIND_ERROR;
      ld_data.format_index = '0;
      ld_data.last = 1'b1;
    end
  end

  // opcode goes first: it is known only at the end, so arguments queue behind
  // it through a second pass; simplest is to walk twice: pass 0 opcode only
  logic pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      formats_in_use <= '0;
      bit_buffer <= '0;
      bit_count <= '0;
      search <= '0;
      pass <= 1'b0;
    end else begin
      if (cfg_we) formats_in_use <= cfg_wdata;
      unique case (state)
        S_IDLE: begin
          search <= '0;
          if (accept && kind == IN_BIT) begin
            if (bit_count >= CW'(MAX_BITS)) begin
              bit_buffer <= BW'(stream_bit);
              bit_count <= CW'(1);
            end else begin
              bit_buffer <= bit_buffer | (BW'(stream_bit) << bit_count);
              bit_count <= bit_count + CW'(1);
            end
            state <= S_READ;
          end
        end
        S_READ: begin
          if (search >= limit) begin
            state <= (bit_count >= CW'(MAX_BITS)) ? S_ERR : S_IDLE;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (hit) begin
            win <= 4'(search);
            pos <= '0; opv <= '0; opw <= '0; argv <= '0; argw <= '0;
            open <= 1'b0; prev_fixed <= 1'b0; pass <= 1'b0;
            state <= S_WALK;
          end else begin
            search <= search + (FW+1)'(1);
            state <= S_READ;
          end
        end
        S_WALK: begin
          if (!ob_full) begin
            if (at_end) begin
              if (!pass) begin
                // opcode emitted, now walk again for the arguments
                if (open) begin
                  pass <= 1'b1;
                  pos <= '0; argv <= '0; argw <= '0; open <= 1'b0;
                  prev_fixed <= 1'b0;
                end else begin
                  bit_buffer <= '0; bit_count <= '0; state <= S_IDLE;
                end
              end else begin
                state <= S_FLUSH;
              end
            end else begin
              pos <= pos + 6'd1;
              if (cur_care) begin
                opv <= opv | (32'(cur_b) << opw[4:0]);
                opw <= opw + 6'd1;
                prev_fixed <= 1'b1;
              end else begin
                if (!open || prev_fixed || cur_run) begin
                  argv <= 32'(cur_b);
                  argw <= 6'd1;
                end else begin
                  argv <= argv | (32'(cur_b) << argw[4:0]);
                  argw <= argw + 6'd1;
                end
                open <= 1'b1;
                prev_fixed <= 1'b0;
              end
            end
          end
        end
        S_FLUSH: begin
          if (!ob_full) begin
            bit_buffer <= '0; bit_count <= '0; state <= S_IDLE;
          end
        end
        S_ERR: begin
          if (!ob_full) begin
            bit_buffer <= '0; bit_count <= '0; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // arguments are only sent on the second pass, opcode only at end of first
  logic ld_gated;
  assign ld_gated = ld && ((state != S_WALK) ||
                           (at_end ? !pass : pass));

  bsfs_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (ld_gated),
    .load_data (ld_data),
    .full      (ob_full),
    .take      (take),
    .data      (ob_data)
  );

  assign out_valid    = ob_full;
  assign item_kind    = ob_data.item_kind;
  assign format_index = ob_data.format_index;
  assign field_value  = ob_data.field_value;
  assign field_width  = ob_data.field_width;
  assign last         = ob_data.last;
endmodule
`default_nettype wire

// ===== hdl/bsfs_checker.sv =====
`default_nettype none
module bsfs_checker
  import bsfs_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] item_kind,
  input wire logic [5:0] field_width,
  input wire logic [31:0] field_value,
  input wire logic       last
);
  // an error item is always alone and empty
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == KIND_ERROR |-> last && field_width == 6'd0)
    else $error("error item malformed");
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> item_kind != 2'd3) else $error("bad item kind");
  // input held off while a result waits
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("accepting while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(field_value))
    else $error("stalled item changed");
endmodule

bind bit_serial_format_splitter_core bsfs_checker u_bsfs_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .item_kind(item_kind), .field_width(field_width),
  .field_value(field_value), .last(last)
);
`default_nettype wire
